FILE: rtl/flba_pkg.sv
// shared types and constants of the free-list block allocator
package flba_pkg;

   // fixed field widths of the request and response beats
   localparam int unsigned FIELD_BITS     = 24;
   localparam int unsigned STATUS_BITS    = 3;
   localparam int unsigned HDR_BITS       = 8;
   localparam int unsigned CSR_INDEX_BITS = 1;

   // operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // status codes
   localparam logic [STATUS_BITS-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_NULL   = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_OOM    = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_FULL   = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_DOUBLE = 3'd4;

   // register indexes and reset values
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIT_POLICY   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEADER_BYTES = 1'd1;
   localparam logic                      FIT_FIRST        = 1'b0;
   localparam logic [HDR_BITS-1:0]       HDR_RESET        = 8'd32;

   typedef struct packed {
      logic                  operation;
      logic [FIELD_BITS-1:0] request_size;
      logic [FIELD_BITS-1:0] block_address;
      logic [FIELD_BITS-1:0] block_size;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [FIELD_BITS-1:0]  granted_address;
      logic [FIELD_BITS-1:0]  heap_bytes;
      logic [FIELD_BITS-1:0]  free_bytes;
   } rsp_type;

   typedef struct packed {
      logic                fit_policy;
      logic [HDR_BITS-1:0] header_bytes;
   } cfg_type;

endpackage

FILE: rtl/flba_mem.sv
// extent table memory: one write port, one registered read port
module flba_mem #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned WIDTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/flba_seq.sv
// sequencer and shared datapath: table scan, decision and table shifting
module flba_seq #(
   parameter int unsigned FREE_ENTRIES = 64,
   parameter int unsigned ADDR_BITS    = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  flba_pkg::cfg_type               cfg,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  flba_pkg::req_type               req_data,
   output logic                            done_valid,
   input  logic                            done_ready,
   output flba_pkg::rsp_type               done_data,
   output logic                            rd_en,
   output logic [$clog2(FREE_ENTRIES)-1:0] rd_addr,
   input  logic [2*((ADDR_BITS > 24) ? ADDR_BITS : 24)-1:0] rd_data,
   output logic                            wr_en,
   output logic [$clog2(FREE_ENTRIES)-1:0] wr_addr,
   output logic [2*((ADDR_BITS > 24) ? ADDR_BITS : 24)-1:0] wr_data
);

   localparam int unsigned IW = $clog2(FREE_ENTRIES);
   localparam int unsigned CW = $clog2(FREE_ENTRIES + 1);
   localparam int unsigned VW = (ADDR_BITS > 24) ? ADDR_BITS : 24;
   localparam int unsigned XW = VW + 2;
   localparam logic [XW-1:0] MASK_X = {{(XW-ADDR_BITS){1'b0}}, {ADDR_BITS{1'b1}}};
   localparam logic [VW-1:0] MASK_V = MASK_X[VW-1:0];
   localparam logic [CW-1:0] FULL_COUNT = CW'(FREE_ENTRIES);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_MOVE   = 3'd3;
   localparam logic [2:0] S_MTAIL  = 3'd4;
   localparam logic [2:0] S_FIN    = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   // saturating add and floor-at-zero subtract
   function automatic logic [VW-1:0] sat_add(input logic [XW-1:0] a, input logic [XW-1:0] b);
      logic [XW-1:0] s;
      s = a + b;
      return (s > MASK_X) ? MASK_V : s[VW-1:0];
   endfunction

   function automatic logic [VW-1:0] sat_sub(input logic [VW-1:0] a, input logic [XW-1:0] b);
      logic [XW-1:0] d;
      d = XW'(a) - b;
      return (XW'(a) > b) ? d[VW-1:0] : '0;
   endfunction

   logic [2:0]                state_ff, state_in;
   logic                      op_ff, op_in;
   logic [VW-1:0]             reqsz_ff, reqsz_in;
   logic [VW-1:0]             s_ff, s_in;
   logic [XW-1:0]             e_ff, e_in;
   logic [VW-1:0]             bsz_ff, bsz_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [VW-1:0]             heap_ff, heap_in;
   logic [VW-1:0]             ftot_ff, ftot_in;
   logic [CW-1:0]             scan_ff, scan_in;
   logic                      pend_ff, pend_in;
   logic [IW-1:0]             pidx_ff, pidx_in;
   logic                      found_ff, found_in;
   logic [IW-1:0]             fidx_ff, fidx_in;
   logic [VW-1:0]             fst_ff, fst_in;
   logic [VW-1:0]             fsz_ff, fsz_in;
   logic [VW-1:0]             bdiff_ff, bdiff_in;
   logic                      dbl_ff, dbl_in;
   logic                      posf_ff, posf_in;
   logic [IW-1:0]             pos_ff, pos_in;
   logic [VW-1:0]             nst_ff, nst_in;
   logic [VW-1:0]             nsz_ff, nsz_in;
   logic                      prevv_ff, prevv_in;
   logic [IW-1:0]             prev_idx_ff, prev_idx_in;
   logic [VW-1:0]             pst_ff, pst_in;
   logic [VW-1:0]             psz_ff, psz_in;
   logic [flba_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic [VW-1:0]             grant_ff, grant_in;
   logic [IW-1:0]             mv_src_ff, mv_src_in;
   logic [IW-1:0]             mv_last_ff, mv_last_in;
   logic                      mv_up_ff, mv_up_in;
   logic                      mv_ins_ff, mv_ins_in;
   logic [IW-1:0]             ins_idx_ff, ins_idx_in;
   logic                      wpend_ff, wpend_in;
   logic [IW-1:0]             wdst_ff, wdst_in;

   logic [VW-1:0] hdr_v;
   logic [VW-1:0] rd_st;
   logic [VW-1:0] rd_sz;
   logic [XW-1:0] need_x;
   logic [XW-1:0] ee_x;
   logic [VW-1:0] diff;
   logic          issue;
   logic          fit;
   logic          exact;
   logic          brk;
   logic          mnext;
   logic          mprev;
   logic          nulreq;
   logic [XW-1:0] nxt_pos;

   assign hdr_v  = VW'(cfg.header_bytes);
   assign rd_st  = rd_data[2*VW-1:VW];
   assign rd_sz  = rd_data[VW-1:0];
   assign need_x = XW'(reqsz_ff) + XW'(hdr_v);
   assign ee_x   = XW'(rd_st) + XW'(hdr_v) + XW'(rd_sz);
   assign diff   = rd_sz - reqsz_ff;
   assign fit    = (rd_sz >= reqsz_ff);
   assign exact  = (rd_sz == reqsz_ff);
   assign mnext  = posf_ff && (e_ff == XW'(nst_ff));
   assign mprev  = prevv_ff && ((XW'(pst_ff) + XW'(hdr_v) + XW'(psz_ff)) == XW'(s_ff));
   assign nxt_pos = XW'(pos_ff) + XW'(1);

   assign req_ready  = (state_ff == S_IDLE);
   assign done_valid = (state_ff == S_DONE);
   assign done_data.status          = status_ff;
   assign done_data.granted_address = grant_ff[flba_pkg::FIELD_BITS-1:0];
   assign done_data.heap_bytes      = heap_ff[flba_pkg::FIELD_BITS-1:0];
   assign done_data.free_bytes      = ftot_ff[flba_pkg::FIELD_BITS-1:0];

   // next-state and datapath
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      reqsz_in    = reqsz_ff;
      s_in        = s_ff;
      e_in        = e_ff;
      bsz_in      = bsz_ff;
      count_in    = count_ff;
      heap_in     = heap_ff;
      ftot_in     = ftot_ff;
      scan_in     = scan_ff;
      pend_in     = pend_ff;
      pidx_in     = pidx_ff;
      found_in    = found_ff;
      fidx_in     = fidx_ff;
      fst_in      = fst_ff;
      fsz_in      = fsz_ff;
      bdiff_in    = bdiff_ff;
      dbl_in      = dbl_ff;
      posf_in     = posf_ff;
      pos_in      = pos_ff;
      nst_in      = nst_ff;
      nsz_in      = nsz_ff;
      prevv_in    = prevv_ff;
      prev_idx_in = prev_idx_ff;
      pst_in      = pst_ff;
      psz_in      = psz_ff;
      status_in   = status_ff;
      grant_in    = grant_ff;
      mv_src_in   = mv_src_ff;
      mv_last_in  = mv_last_ff;
      mv_up_in    = mv_up_ff;
      mv_ins_in   = mv_ins_ff;
      ins_idx_in  = ins_idx_ff;
      wpend_in    = wpend_ff;
      wdst_in     = wdst_ff;
      rd_en       = 1'b0;
      rd_addr     = scan_ff[IW-1:0];
      wr_en       = 1'b0;
      wr_addr     = wdst_ff;
      wr_data     = rd_data;
      issue       = 1'b0;
      brk         = 1'b0;
      nulreq      = 1'b0;

      unique case (state_ff)
         // take a request beat and screen the trivial cases
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_data.operation;
               reqsz_in  = VW'(req_data.request_size);
               bsz_in    = VW'(req_data.block_size);
               s_in      = VW'(req_data.block_address) - hdr_v;
               e_in      = XW'(req_data.block_address) + XW'(req_data.block_size);
               scan_in   = '0;
               pend_in   = 1'b0;
               found_in  = 1'b0;
               dbl_in    = 1'b0;
               posf_in   = 1'b0;
               prevv_in  = 1'b0;
               grant_in  = '0;
               status_in = flba_pkg::ST_OK;
               if (req_data.operation == flba_pkg::OP_ALLOC) begin
                  nulreq = (req_data.request_size == '0);
               end else begin
                  nulreq = (req_data.block_address == '0) ||
                           (VW'(req_data.block_address) < hdr_v);
               end
               if (nulreq) begin
                  status_in = flba_pkg::ST_NULL;
                  state_in  = S_DONE;
               end else begin
                  state_in  = S_SCAN;
               end
            end
         end

         // walk the table, one entry read per cycle
         S_SCAN: begin
            issue   = (scan_ff < count_ff);
            pend_in = issue;
            if (issue) begin
               rd_en   = 1'b1;
               rd_addr = scan_ff[IW-1:0];
               scan_in = scan_ff + CW'(1);
               pidx_in = scan_ff[IW-1:0];
            end
            if (pend_ff) begin
               if (op_ff == flba_pkg::OP_ALLOC) begin
                  brk = fit && ((cfg.fit_policy == flba_pkg::FIT_FIRST) || exact);
                  if (fit && ((cfg.fit_policy == flba_pkg::FIT_FIRST) || exact ||
                              !found_ff || (diff < bdiff_ff))) begin
                     found_in = 1'b1;
                     fidx_in  = pidx_ff;
                     fst_in   = rd_st;
                     fsz_in   = rd_sz;
                     bdiff_in = diff;
                  end
               end else begin
                  if ((rd_st == s_ff) || ((XW'(s_ff) < ee_x) && (XW'(rd_st) < e_ff))) begin
                     dbl_in = 1'b1;
                  end
                  if (!posf_ff) begin
                     if (rd_st > s_ff) begin
                        posf_in = 1'b1;
                        pos_in  = pidx_ff;
                        nst_in  = rd_st;
                        nsz_in  = rd_sz;
                     end else begin
                        prevv_in    = 1'b1;
                        prev_idx_in = pidx_ff;
                        pst_in      = rd_st;
                        psz_in      = rd_sz;
                     end
                  end
               end
            end
            if (brk || !issue) begin
               pend_in  = 1'b0;
               state_in = S_DECIDE;
            end
         end

         // apply the outcome of the scan
         S_DECIDE: begin
            wpend_in  = 1'b0;
            mv_ins_in = 1'b0;
            state_in  = S_DONE;
            if (op_ff == flba_pkg::OP_ALLOC) begin
               if (found_ff) begin
                  grant_in = VW'((XW'(fst_ff) + XW'(hdr_v)) & MASK_X);
                  if (XW'(fsz_ff) > need_x) begin
                     wr_en   = 1'b1;
                     wr_addr = fidx_ff;
                     wr_data = {VW'((XW'(fst_ff) + need_x) & MASK_X),
                                VW'(XW'(fsz_ff) - need_x)};
                     ftot_in = sat_sub(ftot_ff, need_x);
                  end else begin
                     ftot_in  = sat_sub(ftot_ff, XW'(fsz_ff) + XW'(hdr_v));
                     count_in = count_ff - CW'(1);
                     if ((CW'(fidx_ff) + CW'(1)) < count_ff) begin
                        mv_src_in  = fidx_ff + IW'(1);
                        mv_last_in = IW'(count_ff - CW'(1));
                        mv_up_in   = 1'b0;
                        state_in   = S_MOVE;
                     end
                  end
               end else if ((XW'(heap_ff) + need_x) > MASK_X) begin
                  status_in = flba_pkg::ST_OOM;
               end else begin
                  grant_in = heap_ff + hdr_v;
                  heap_in  = VW'(XW'(heap_ff) + need_x);
               end
            end else if (dbl_ff) begin
               status_in = flba_pkg::ST_DOUBLE;
            end else if (mnext && mprev) begin
               wr_en    = 1'b1;
               wr_addr  = prev_idx_ff;
               wr_data  = {pst_ff, sat_add(XW'(psz_ff), XW'(hdr_v) + XW'(bsz_ff) +
                                           XW'(hdr_v) + XW'(nsz_ff))};
               ftot_in  = sat_add(XW'(ftot_ff), XW'(bsz_ff) + XW'(hdr_v));
               count_in = count_ff - CW'(1);
               if (nxt_pos < XW'(count_ff)) begin
                  mv_src_in  = pos_ff + IW'(1);
                  mv_last_in = IW'(count_ff - CW'(1));
                  mv_up_in   = 1'b0;
                  state_in   = S_MOVE;
               end
            end else if (mprev) begin
               wr_en   = 1'b1;
               wr_addr = prev_idx_ff;
               wr_data = {pst_ff, sat_add(XW'(psz_ff), XW'(hdr_v) + XW'(bsz_ff))};
               ftot_in = sat_add(XW'(ftot_ff), XW'(bsz_ff) + XW'(hdr_v));
            end else if (mnext) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff;
               wr_data = {s_ff, sat_add(XW'(nsz_ff), XW'(bsz_ff) + XW'(hdr_v))};
               ftot_in = sat_add(XW'(ftot_ff), XW'(bsz_ff) + XW'(hdr_v));
            end else if (count_ff >= FULL_COUNT) begin
               status_in = flba_pkg::ST_FULL;
            end else begin
               ftot_in   = sat_add(XW'(ftot_ff), XW'(bsz_ff) + XW'(hdr_v));
               count_in  = count_ff + CW'(1);
               mv_ins_in = 1'b1;
               if (posf_ff) begin
                  ins_idx_in = pos_ff;
                  mv_src_in  = IW'(count_ff - CW'(1));
                  mv_last_in = pos_ff;
                  mv_up_in   = 1'b1;
                  state_in   = S_MOVE;
               end else begin
                  ins_idx_in = IW'(count_ff);
                  state_in   = S_FIN;
               end
            end
         end

         // shift entries one place, read one and write the previous
         S_MOVE: begin
            rd_en   = 1'b1;
            rd_addr = mv_src_ff;
            if (wpend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wdst_ff;
               wr_data = rd_data;
            end
            wpend_in  = 1'b1;
            wdst_in   = mv_up_ff ? (mv_src_ff + IW'(1)) : (mv_src_ff - IW'(1));
            mv_src_in = mv_up_ff ? (mv_src_ff - IW'(1)) : (mv_src_ff + IW'(1));
            if (mv_src_ff == mv_last_ff) begin
               state_in = S_MTAIL;
            end
         end

         // last write of the shift
         S_MTAIL: begin
            wr_en    = 1'b1;
            wr_addr  = wdst_ff;
            wr_data  = rd_data;
            wpend_in = 1'b0;
            state_in = mv_ins_ff ? S_FIN : S_DONE;
         end

         // place the new extent
         S_FIN: begin
            wr_en    = 1'b1;
            wr_addr  = ins_idx_ff;
            wr_data  = {s_ff, bsz_ff};
            state_in = S_DONE;
         end

         // hand the result to the output register
         S_DONE: begin
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         heap_ff  <= '0;
         ftot_ff  <= '0;
         pend_ff  <= 1'b0;
         wpend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         heap_ff  <= heap_in;
         ftot_ff  <= ftot_in;
         pend_ff  <= pend_in;
         wpend_ff <= wpend_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      reqsz_ff    <= reqsz_in;
      s_ff        <= s_in;
      e_ff        <= e_in;
      bsz_ff      <= bsz_in;
      scan_ff     <= scan_in;
      pidx_ff     <= pidx_in;
      found_ff    <= found_in;
      fidx_ff     <= fidx_in;
      fst_ff      <= fst_in;
      fsz_ff      <= fsz_in;
      bdiff_ff    <= bdiff_in;
      dbl_ff      <= dbl_in;
      posf_ff     <= posf_in;
      pos_ff      <= pos_in;
      nst_ff      <= nst_in;
      nsz_ff      <= nsz_in;
      prevv_ff    <= prevv_in;
      prev_idx_ff <= prev_idx_in;
      pst_ff      <= pst_in;
      psz_ff      <= psz_in;
      status_ff   <= status_in;
      grant_ff    <= grant_in;
      mv_src_ff   <= mv_src_in;
      mv_last_ff  <= mv_last_in;
      mv_up_ff    <= mv_up_in;
      mv_ins_ff   <= mv_ins_in;
      ins_idx_ff  <= ins_idx_in;
      wdst_ff     <= wdst_in;
   end

endmodule

FILE: rtl/free_list_block_allocator.sv
// top level of the free-list block allocator
//
// Heap allocator keeping an address-sorted table of free extents.
// Request channel (req_): one beat is an allocate or a free; the block takes
// one beat at a time and drops req_ready while it works on it.
// Response channel (rsp_): one beat per request with status, granted address,
// heap top and free-byte total, held in an output register.
// Register port (csr_): index 0 fit policy, index 1 header bytes; always ready.
// A zero allocate or null free answers without a scan. Otherwise the request
// scans the table one entry per cycle through the table memory's read port,
// decides, and when an entry is removed or inserted shifts the table tail
// one entry per cycle through the same read and write ports.
// Reset empties the table, zeroes heap top and free total, and restores the
// registers to first fit and 32 header bytes; the table needs no clearing.
// A stalled response holds in the output register; the next request can be
// worked on meanwhile, and its result waits until the register frees up.
module free_list_block_allocator #(
   parameter int unsigned FREE_ENTRIES = 64,
   parameter int unsigned ADDR_BITS    = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  flba_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output flba_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [flba_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [flba_pkg::HDR_BITS-1:0]          csr_data
);

   localparam int unsigned IW = $clog2(FREE_ENTRIES);
   localparam int unsigned VW = (ADDR_BITS > 24) ? ADDR_BITS : 24;

   flba_pkg::cfg_type cfg_ff, cfg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   flba_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic              done_valid;
   logic              done_ready;
   flba_pkg::rsp_type done_data;
   logic              rd_en;
   logic [IW-1:0]     rd_addr;
   logic [2*VW-1:0]   rd_data;
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   logic [2*VW-1:0]   wr_data;

   // configuration registers
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            flba_pkg::CSR_FIT_POLICY:   cfg_in.fit_policy   = csr_data[0];
            flba_pkg::CSR_HEADER_BYTES: cfg_in.header_bytes = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   // response output register
   assign done_ready = !rsp_valid_ff || rsp_ready;
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = done_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fit_policy   <= flba_pkg::FIT_FIRST;
         cfg_ff.header_bytes <= flba_pkg::HDR_RESET;
         rsp_valid_ff        <= 1'b0;
      end else begin
         cfg_ff              <= cfg_in;
         rsp_valid_ff        <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer and datapath
   flba_seq #(
      .FREE_ENTRIES (FREE_ENTRIES),
      .ADDR_BITS    (ADDR_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done_data  (done_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   // extent table
   flba_mem #(
      .DEPTH (FREE_ENTRIES),
      .WIDTH (2*VW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

FILE: rtl/flba_checker.sv
// port checker for the free-list block allocator, bound to the top level
module flba_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input flba_pkg::rsp_type rsp_data
);

   // a stalled response beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat dropped or changed while stalled");

   // status is one of the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == flba_pkg::ST_OK) ||
                    (rsp_data.status == flba_pkg::ST_NULL) ||
                    (rsp_data.status == flba_pkg::ST_OOM) ||
                    (rsp_data.status == flba_pkg::ST_FULL) ||
                    (rsp_data.status == flba_pkg::ST_DOUBLE))
      else $error("undefined status");

   // a failed request grants nothing
   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != flba_pkg::ST_OK) |-> rsp_data.granted_address == '0)
      else $error("address granted on a failed request");

   // reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

   // an accepted request is not followed by another in the next cycle
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

endmodule

bind free_list_block_allocator flba_checker u_flba_checker (.*);

FILE: tb/sv/tb.sv
// self-checking testbench of the free-list block allocator
module tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TABLE_DEPTH   = 64;
   localparam longint      ADDR_MAX      = (64'd1 << 24) - 1;
   localparam int unsigned SETTLE_CYCLES = 2 * TABLE_DEPTH + 20;
   localparam int unsigned IDLE_LIMIT    = 40000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   flba_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   flba_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [flba_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [flba_pkg::HDR_BITS-1:0]       csr_data = '0;

   free_list_block_allocator dut (.*);

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // allocator shadow state
   longint      ext_start [TABLE_DEPTH];
   longint      ext_size [TABLE_DEPTH];
   int unsigned ext_count;
   longint      top_of_heap;
   longint      free_sum;
   logic        best_fit;
   longint      hdr_len;

   flba_pkg::rsp_type pending_rsps [$];
   int unsigned error_count;
   int unsigned rsp_count;
   int unsigned idle_cycles;
   int unsigned status_seen [5];
   logic [23:0] live_addr [$];
   logic [23:0] live_size [$];

   function automatic longint sat_plus(longint a, longint b);
      return (a + b > ADDR_MAX) ? ADDR_MAX : a + b;
   endfunction

   function automatic void drop_extent(int unsigned idx);
      for (int unsigned i = idx; i + 1 < ext_count; i++) begin
         ext_start[i] = ext_start[i+1];
         ext_size[i]  = ext_size[i+1];
      end
      ext_count--;
   endfunction

   // allocate: pick an extent, split or take it whole, else grow the heap
   function automatic logic [2:0] predict_alloc(longint req, output longint grant);
      longint need;
      longint best;
      int     found;
      need  = req + hdr_len;
      best  = 64'h7fffffffffffffff;
      found = -1;
      grant = 0;
      if (req == 0) return flba_pkg::ST_NULL;
      for (int i = 0; i < int'(ext_count); i++) begin
         if (ext_size[i] < req) continue;
         if (!best_fit || ext_size[i] == req) begin
            found = i;
            break;
         end
         if (ext_size[i] - req < best) begin
            best  = ext_size[i] - req;
            found = i;
         end
      end
      if (found >= 0) begin
         grant = (ext_start[found] + hdr_len) & ADDR_MAX;
         if (ext_size[found] > need) begin
            ext_start[found] = (ext_start[found] + need) & ADDR_MAX;
            ext_size[found] -= need;
            free_sum = (free_sum > need) ? free_sum - need : 0;
         end else begin
            free_sum = (free_sum > ext_size[found] + hdr_len) ?
                       free_sum - (ext_size[found] + hdr_len) : 0;
            drop_extent(found);
         end
         return flba_pkg::ST_OK;
      end
      if (top_of_heap + need > ADDR_MAX) return flba_pkg::ST_OOM;
      grant = top_of_heap + hdr_len;
      top_of_heap += need;
      return flba_pkg::ST_OK;
   endfunction

   // free: sorted insert with coalescing of neighbours
   function automatic logic [2:0] predict_free(longint addr, longint bsz);
      longint      s;
      longint      e;
      longint      es;
      longint      ee;
      int unsigned pos;
      bit          join_next;
      bit          join_prev;
      if (addr == 0 || addr < hdr_len) return flba_pkg::ST_NULL;
      s   = addr - hdr_len;
      e   = s + hdr_len + bsz;
      pos = ext_count;
      for (int unsigned i = 0; i < ext_count; i++) begin
         es = ext_start[i];
         ee = es + hdr_len + ext_size[i];
         if (es == s || (s < ee && es < e)) return flba_pkg::ST_DOUBLE;
         if (es > s && pos == ext_count) pos = i;
      end
      join_next = pos < ext_count && e == ext_start[pos];
      join_prev = pos > 0 && ext_start[pos-1] + hdr_len + ext_size[pos-1] == s;
      if (join_next && join_prev) begin
         ext_size[pos-1] = sat_plus(ext_size[pos-1],
                                    hdr_len + bsz + hdr_len + ext_size[pos]);
         drop_extent(pos);
      end else if (join_prev) begin
         ext_size[pos-1] = sat_plus(ext_size[pos-1], hdr_len + bsz);
      end else if (join_next) begin
         ext_start[pos] = s;
         ext_size[pos]  = sat_plus(ext_size[pos], bsz + hdr_len);
      end else begin
         if (ext_count >= TABLE_DEPTH) return flba_pkg::ST_FULL;
         for (int unsigned i = ext_count; i > pos; i--) begin
            ext_start[i] = ext_start[i-1];
            ext_size[i]  = ext_size[i-1];
         end
         ext_start[pos] = s;
         ext_size[pos]  = bsz;
         ext_count++;
      end
      free_sum = sat_plus(free_sum, bsz + hdr_len);
      return flba_pkg::ST_OK;
   endfunction

   function automatic flba_pkg::rsp_type predict_response(flba_pkg::req_type r);
      flba_pkg::rsp_type p;
      longint            grant;
      grant = 0;
      if (r.operation == flba_pkg::OP_ALLOC) p.status = predict_alloc(r.request_size, grant);
      else p.status = predict_free(r.block_address, r.block_size);
      if (p.status != flba_pkg::ST_OK) grant = 0;
      p.granted_address = grant[23:0];
      p.heap_bytes      = top_of_heap[23:0];
      p.free_bytes      = free_sum[23:0];
      return p;
   endfunction

   // sender gap state: bursts of random length with random gaps
   int unsigned burst_left;

   task automatic send_beat(flba_pkg::req_type r);
      flba_pkg::rsp_type p;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 30)) @(negedge clock);
      end
      burst_left--;
      // valid drops between beats
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      p = predict_response(r);
      pending_rsps.push_back(p);
      if (r.operation == flba_pkg::OP_ALLOC && p.status == flba_pkg::ST_OK &&
          live_addr.size() < 200) begin
         live_addr.push_back(p.granted_address);
         live_size.push_back(r.request_size);
      end
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic send_alloc(logic [23:0] sz);
      flba_pkg::req_type r;
      r = '0;
      r.operation    = flba_pkg::OP_ALLOC;
      r.request_size = sz;
      r.block_address = 24'($urandom());
      r.block_size   = 24'($urandom());
      send_beat(r);
   endtask

   task automatic send_free(logic [23:0] addr, logic [23:0] sz);
      flba_pkg::req_type r;
      r = '0;
      r.operation     = flba_pkg::OP_FREE;
      r.request_size  = 24'($urandom());
      r.block_address = addr;
      r.block_size    = sz;
      send_beat(r);
   endtask

   // wait for every response, then let the block go quiet
   task automatic drain();
      while (pending_rsps.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [flba_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [flba_pkg::HDR_BITS-1:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == flba_pkg::CSR_FIT_POLICY) best_fit = val[0];
      else hdr_len = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic free_random_live();
      int unsigned k;
      k = $urandom_range(0, live_addr.size() - 1);
      send_free(live_addr[k], live_size[k]);
      live_addr.delete(k);
      live_size.delete(k);
   endtask

   // response checker and receiver stall pattern
   always @(posedge clock) begin
      flba_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         idle_cycles = 0;
         rsp_count++;
         if (pending_rsps.size() == 0) begin
            $display("%0t: unexpected response %p", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_rsps.pop_front();
            if (want.status <= flba_pkg::ST_DOUBLE) status_seen[want.status]++;
            if (rsp_data.status != want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.granted_address != want.granted_address) begin
               $display("%0t: granted_address expected %h actual %h", $time,
                        want.granted_address, rsp_data.granted_address);
               error_count++;
            end
            if (rsp_data.heap_bytes != want.heap_bytes) begin
               $display("%0t: heap_bytes expected %h actual %h", $time,
                        want.heap_bytes, rsp_data.heap_bytes);
               error_count++;
            end
            if (rsp_data.free_bytes != want.free_bytes) begin
               $display("%0t: free_bytes expected %h actual %h", $time,
                        want.free_bytes, rsp_data.free_bytes);
               error_count++;
            end
         end
      end else if ((req_valid && req_ready) || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding", pending_rsps.size());
         $display("free_list_block_allocator verification failed");
         $finish;
      end
   end

   int unsigned stall_phase;
   always @(negedge clock) begin
      stall_phase++;
      if (stall_phase[8]) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   // directed: zero sizes, null and low frees, extremes of fields
   task automatic test_special_cases();
      send_alloc(24'd0);
      send_free(24'd0, 24'hFFFFFF);
      send_free(24'd31, 24'd10);
      send_alloc(24'd1);
      send_alloc(24'hFFFFFF);
      send_alloc(24'd100);
      send_alloc(24'd200);
      send_alloc(24'd50);
      send_free(24'd65, 24'd100);
      send_free(24'd65, 24'd100);
      send_free(24'd197, 24'd200);
      send_free(24'd32, 24'd1);
      send_free(24'd40, 24'd5);
      send_alloc(24'd150);
      send_alloc(24'd10);
      send_alloc(24'hFFFF00);
      send_free(24'hFFFFFF, 24'hFFFFFF);
   endtask

   // allocations and a free with a zero header
   task automatic test_zero_header();
      send_alloc(24'd16);
      send_alloc(24'd16);
      send_free(24'd16, 24'd16);
      send_alloc(24'd8);
   endtask

   // fill the free table with separated holes until it overflows
   task automatic test_table_full();
      logic [23:0] base;
      base = 24'h800000;
      for (int i = 0; i < TABLE_DEPTH + 3; i++) send_free(base + 24'(i * 64), 24'd8);
      send_alloc(24'd8);
      send_free(base + 24'(TABLE_DEPTH * 64 + 256), 24'd4);
   endtask

   // random mix of well-formed alloc/free pairs and noise
   task automatic test_random_traffic(int unsigned count);
      flba_pkg::req_type r;
      for (int unsigned n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               if ($urandom_range(0, 7) == 0) send_alloc(24'($urandom()));
               else send_alloc(24'($urandom_range(1, 600)));
            end
            4, 5, 6, 7: begin
               if (live_addr.size() != 0) free_random_live();
               else send_alloc(24'($urandom_range(1, 300)));
            end
            8: send_free(24'($urandom_range(0, 4000)), 24'($urandom_range(0, 300)));
            default: begin
               r = '0;
               r.operation     = 1'($urandom_range(0, 1));
               r.request_size  = 24'($urandom());
               r.block_address = 24'($urandom());
               r.block_size    = 24'($urandom());
               send_beat(r);
            end
         endcase
         if (n == count / 2) drain();
      end
   endtask

   initial begin
      ext_count   = 0;
      top_of_heap = 0;
      free_sum    = 0;
      best_fit    = flba_pkg::FIT_FIRST;
      hdr_len     = flba_pkg::HDR_RESET;
      error_count = 0;
      rsp_count   = 0;
      idle_cycles = 0;
      burst_left  = 0;
      stall_phase = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_special_cases();
      write_csr(flba_pkg::CSR_HEADER_BYTES, 8'd0);
      test_zero_header();
      write_csr(flba_pkg::CSR_FIT_POLICY, 8'd1);
      test_table_full();
      live_addr.delete();
      live_size.delete();
      test_random_traffic(105);
      write_csr(flba_pkg::CSR_HEADER_BYTES, 8'd255);
      write_csr(flba_pkg::CSR_FIT_POLICY, 8'd0);
      test_random_traffic(105);
      write_csr(flba_pkg::CSR_HEADER_BYTES, 8'd16);
      write_csr(flba_pkg::CSR_FIT_POLICY, 8'd1);
      test_random_traffic(105);
      drain();

      $display("%0d responses checked: ok %0d, null %0d, oom %0d, full %0d, double %0d",
               rsp_count, status_seen[0], status_seen[1], status_seen[2],
               status_seen[3], status_seen[4]);
      $display("headers 0/16/32/255 under first and best fit, with heap growth and coalescing");
      if (error_count == 0 && pending_rsps.size() == 0) begin
         $display("free_list_block_allocator verification clean");
      end else begin
         $display("free_list_block_allocator verification failed");
      end
      $finish;
   end

endmodule
